>>> src/rsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the surface life-cycle function of the surface pool.
// No dependencies; used by every module of the block.
package rsp_pkg;

    // Pool size and derived widths
    localparam int NUM_SURFACES = 16;
    localparam int SIDX_W       = (NUM_SURFACES > 1) ? $clog2(NUM_SURFACES) : 1;
    localparam int WIDE_W       = 7;   // holds any pool index or count up to 64
    localparam int IDX_W        = 4;   // surface_index / grant_index field width
    localparam int MASK_W       = 16;  // ready_mask field width
    localparam int ACT_W        = 2;
    localparam int STAT_W       = 3;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOCATE  = 2'd0,
        ACT_RENDER    = 2'd1,
        ACT_RELEASE   = 2'd2,
        ACT_DISPLAYED = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_FREE           = 3'd0,
        ST_ALOC           = 3'd1,
        ST_RENDER         = 3'd2,
        ST_RENDER_RELEASE = 3'd3,
        ST_RELEASED       = 3'd4
    } surf_state_t;

    // Write request into the status file
    typedef struct packed {
        logic              we;
        logic [SIDX_W-1:0] addr;
        surf_state_t       data;
    } st_wr_t;

    // One finished result from the sequencer
    typedef struct packed {
        logic             valid;
        logic             granted;
        logic [IDX_W-1:0] grant_index;
        logic             no_free;
        logic             order_error;
        surf_state_t      new_status;
    } result_t;

    typedef struct packed {
        logic        err;
        surf_state_t status;
    } transition_t;

    // Life-cycle step for render, release and displayed
    function automatic transition_t apply_action(action_t act, surf_state_t s);
        transition_t t;
        t.err    = 1'b0;
        t.status = s;
        case (act)
            ACT_RENDER:
            begin
                t.err    = (s != ST_ALOC);
                t.status = ST_RENDER;
            end
            ACT_RELEASE:
            begin
                t.err = !((s == ST_ALOC) || (s == ST_RENDER) || (s == ST_RELEASED));
                if (s == ST_RENDER)
                    t.status = ST_RENDER_RELEASE;
                else if (s != ST_RENDER_RELEASE)
                    t.status = ST_FREE;
            end
            ACT_DISPLAYED:
            begin
                if (s == ST_RENDER_RELEASE)
                    t.status = ST_FREE;
                else if (s == ST_RENDER)
                    t.status = ST_RELEASED;
                else
                    t.err = 1'b1;
            end
            default:
            begin
                t.err    = 1'b0;
                t.status = s;
            end
        endcase
        return t;
    endfunction

endpackage

>>> src/render_surface_pool.sv
`timescale 1ns / 1ps
// Top level of the surface pool: stream ports, configuration register, output register.
// Depends on rsp_pkg, rsp_status_file and rsp_seq.

// Pool of NUM_SURFACES frame buffers, each free, allocated, rendering,
// render-then-release or released. One request is handled at a time and every
// request yields exactly one result. Render, release and displayed pass from the
// update state into the output register once that register is free. Allocate
// probes one surface per cycle round-robin from the head pointer through the
// single status read port and compare, until a hit or a full pass, waiting while the
// output register is full; the head moves past a granted surface and stays put
// when nothing was granted. s_tready is high only while no request is in progress;
// a finished result waits in the output register without blocking the next request.
// query_status_enable may be written only while the block is idle.
module render_surface_pool (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] surface_index, [19:4] ready_mask, [23:20] zero
    input  logic [rsp_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] action
    input  logic [rsp_pkg::ACT_W-1:0]     s_tuser,
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] granted, [4:1] grant_index, [5] no_free, [6] order_error,
    // [9:7] new_status, [15:10] zero
    output logic [rsp_pkg::M_TDATA_W-1:0] m_tdata,
    // Configuration write: query_status_enable
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    logic                       query_en_reg;
    logic                       m_tvalid_reg;
    rsp_pkg::result_t           out_reg;
    logic                       out_free;
    logic [rsp_pkg::SIDX_W-1:0] rd_addr;
    rsp_pkg::surf_state_t       rd_data;
    rsp_pkg::st_wr_t            st_wr;
    rsp_pkg::result_t           res;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            query_en_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            query_en_reg <= cfg_data;
    end

    rsp_status_file u_status (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (st_wr)
    );

    rsp_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .action        (s_tuser),
        .surface_index (s_tdata[rsp_pkg::IDX_W-1:0]),
        .ready_mask    (s_tdata[rsp_pkg::IDX_W +: rsp_pkg::MASK_W]),
        .query_en      (query_en_reg),
        .out_free      (out_free),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .st_wr         (st_wr),
        .res           (res)
    );

    // Output register: empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res.valid)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
            out_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_reg.new_status, out_reg.order_error, out_reg.no_free,
                       out_reg.grant_index, out_reg.granted};

endmodule

>>> src/rsp_status_file.sv
`timescale 1ns / 1ps
// Per-surface state store: one read address, one write port, cleared to free on reset.
// Depends on rsp_pkg.
module rsp_status_file (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rsp_pkg::SIDX_W-1:0] rd_addr,
    output rsp_pkg::surf_state_t       rd_data,
    input  rsp_pkg::st_wr_t            wr
);

    rsp_pkg::surf_state_t status_reg [rsp_pkg::NUM_SURFACES];

    // Write port; every surface starts free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rsp_pkg::NUM_SURFACES; i++)
                status_reg[i] <= rsp_pkg::ST_FREE;
        end
        else if (wr.we)
        begin
            status_reg[wr.addr] <= wr.data;
        end
    end

    // Single read port
    assign rd_data = status_reg[rd_addr];

endmodule

>>> src/rsp_seq.sv
`timescale 1ns / 1ps
// Sequencer: takes one request, probes the status file one surface per cycle for
// allocate, applies the life-cycle step otherwise. Depends on rsp_pkg.
module rsp_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rsp_pkg::ACT_W-1:0]  action,
    input  logic [rsp_pkg::IDX_W-1:0]  surface_index,
    input  logic [rsp_pkg::MASK_W-1:0] ready_mask,
    input  logic                       query_en,
    input  logic                       out_free,
    output logic [rsp_pkg::SIDX_W-1:0] rd_addr,
    input  rsp_pkg::surf_state_t       rd_data,
    output rsp_pkg::st_wr_t            st_wr,
    output rsp_pkg::result_t           res
);

    typedef enum logic [2:0] {
        SQ_IDLE   = 3'b001,
        SQ_SCAN   = 3'b010,
        SQ_UPDATE = 3'b100
    } seq_state_t;

    seq_state_t                  state_reg, state_next;
    rsp_pkg::action_t            act_reg, act_next;
    logic [rsp_pkg::IDX_W-1:0]   sidx_reg, sidx_next;
    logic [rsp_pkg::MASK_W-1:0]  mask_reg, mask_next;
    logic [rsp_pkg::SIDX_W-1:0]  pos_reg, pos_next;
    logic [rsp_pkg::SIDX_W-1:0]  cnt_reg, cnt_next;
    logic [rsp_pkg::SIDX_W-1:0]  head_reg, head_next;

    logic                        in_pool;
    logic [rsp_pkg::WIDE_W-1:0]  pos_w;
    logic                        mask_hit;
    logic                        hit;
    logic                        last_probe;
    logic [rsp_pkg::SIDX_W-1:0]  pos_inc;
    rsp_pkg::transition_t        trans;

    assign s_tready = (state_reg == SQ_IDLE);

    // Addressed surface must lie inside the pool
    assign in_pool = rsp_pkg::WIDE_W'(sidx_reg) < rsp_pkg::WIDE_W'(rsp_pkg::NUM_SURFACES);

    // Shared read port: scan pointer while scanning, addressed surface otherwise (0 when outside the pool)
    always_comb
    begin
        if (state_reg == SQ_SCAN)
            rd_addr = pos_reg;
        else if (in_pool)
            rd_addr = rsp_pkg::SIDX_W'(sidx_reg);
        else
            rd_addr = '0;
    end

    // Probe compare: free and ready (surfaces past the mask never ready when querying)
    assign pos_w      = rsp_pkg::WIDE_W'(pos_reg);
    assign mask_hit   = (pos_w < rsp_pkg::WIDE_W'(rsp_pkg::MASK_W)) ?
                        mask_reg[pos_w[rsp_pkg::IDX_W-1:0]] : 1'b0;
    assign hit        = (rd_data == rsp_pkg::ST_FREE) && (!query_en || mask_hit);
    assign last_probe = (cnt_reg == rsp_pkg::SIDX_W'(rsp_pkg::NUM_SURFACES - 1));
    assign pos_inc    = (pos_reg == rsp_pkg::SIDX_W'(rsp_pkg::NUM_SURFACES - 1)) ?
                        '0 : pos_reg + 1'b1;
    assign trans      = rsp_pkg::apply_action(act_reg, rd_data);

    // Next state, status writes and result
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        sidx_next  = sidx_reg;
        mask_next  = mask_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        st_wr      = '0;
        res        = '0;

        unique case (state_reg)
            SQ_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next  = rsp_pkg::action_t'(action);
                    sidx_next = surface_index;
                    mask_next = ready_mask;
                    pos_next  = head_reg;
                    cnt_next  = '0;
                    if (rsp_pkg::action_t'(action) == rsp_pkg::ACT_ALLOCATE)
                        state_next = SQ_SCAN;
                    else
                        state_next = SQ_UPDATE;
                end
            end
            SQ_SCAN:
            begin
                if (hit || last_probe)
                begin
                    if (out_free)
                    begin
                        res.valid = 1'b1;
                        if (hit)
                        begin
                            res.granted     = 1'b1;
                            res.grant_index = rsp_pkg::IDX_W'(pos_reg);
                            res.new_status  = rsp_pkg::ST_ALOC;
                            st_wr.we        = 1'b1;
                            st_wr.addr      = pos_reg;
                            st_wr.data      = rsp_pkg::ST_ALOC;
                            head_next       = pos_inc;
                        end
                        else
                        begin
                            res.no_free    = 1'b1;
                            res.new_status = rsp_pkg::ST_FREE;
                        end
                        state_next = SQ_IDLE;
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SQ_UPDATE:
            begin
                if (out_free)
                begin
                    res.valid = 1'b1;
                    if (in_pool)
                    begin
                        res.order_error = trans.err;
                        res.new_status  = trans.status;
                        st_wr.we        = 1'b1;
                        st_wr.addr      = rd_addr;
                        st_wr.data      = trans.status;
                    end
                    else
                    begin
                        res.order_error = 1'b1;
                        res.new_status  = rsp_pkg::ST_FREE;
                    end
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            head_reg  <= '0;
            pos_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Request payload
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        sidx_reg <= sidx_next;
        mask_reg <= mask_next;
    end

    // Status only changes together with a delivered result
    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        st_wr.we |-> res.valid)
        else $error("status write without a result");

    // Result only issued when the output slot can take it
    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> out_free)
        else $error("result issued while output slot full");

    // Scan never probes more than one full pass
    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_SCAN) |->
        (rsp_pkg::WIDE_W'(cnt_reg) < rsp_pkg::WIDE_W'(rsp_pkg::NUM_SURFACES)))
        else $error("scan count beyond pool size");

    // A grant excludes the other outcome flags
    a_grant_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res.granted |-> (res.valid && !res.no_free && !res.order_error))
        else $error("grant with no_free or order_error");

    // Head pointer moves only after a grant
    a_head_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != $past(head_reg)) |-> $past(res.granted))
        else $error("head pointer moved without a grant");

endmodule

>>> verif/tb_render_surface_pool.sv
`timescale 1ns / 1ps
// Self-checking bench for render_surface_pool: a life-cycle ledger predicts every result.
// Depends on rsp_pkg and render_surface_pool; stream sides idle and stall at random.
module tb_render_surface_pool;
    import rsp_pkg::*;

    // Expected result of one request, fields as they appear on m_tdata
    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] grant_index;
        logic             no_free;
        logic             order_error;
        surf_state_t      new_status;
    } pool_outcome_t;

    // Surface ledger: mirrors the pool and queues the outcomes still to come
    class surface_ledger;
        surf_state_t   status [NUM_SURFACES];
        int unsigned   head;
        bit            query_on;
        pool_outcome_t pending_results[$];
        int unsigned   failures;
        int unsigned   checked;
        int unsigned   grants;
        int unsigned   exhausted;
        int unsigned   order_errors;

        function new();
            foreach (status[i])
                status[i] = ST_FREE;
            head         = 0;
            query_on     = 1'b1;
            failures     = 0;
            checked      = 0;
            grants       = 0;
            exhausted    = 0;
            order_errors = 0;
        endfunction

        // Apply one accepted request to the mirrored pool
        function void note_request(action_t act, logic [IDX_W-1:0] idx,
                                   logic [MASK_W-1:0] mask);
            pool_outcome_t res;
            int unsigned   pos;
            bit            found;
            surf_state_t   s;
            res   = '0;
            found = 1'b0;
            if (act == ACT_ALLOCATE)
            begin
                // one round-robin pass from the head
                pos = head;
                for (int n = 0; n < NUM_SURFACES; n++)
                begin
                    if (!found && status[pos] == ST_FREE &&
                        (!query_on || (pos < MASK_W && mask[pos])))
                    begin
                        found           = 1'b1;
                        status[pos]     = ST_ALOC;
                        res.granted     = 1'b1;
                        res.grant_index = pos[IDX_W-1:0];
                        res.new_status  = ST_ALOC;
                        head            = (pos + 1) % NUM_SURFACES;
                    end
                    pos = (pos + 1) % NUM_SURFACES;
                end
                res.no_free = !found;
            end
            else if (idx >= NUM_SURFACES)
            begin
                res.order_error = 1'b1;
            end
            else
            begin
                s = status[idx];
                case (act)
                    ACT_RENDER:
                    begin
                        res.order_error = (s != ST_ALOC);
                        s = ST_RENDER;
                    end
                    ACT_RELEASE:
                    begin
                        res.order_error = !(s == ST_ALOC || s == ST_RENDER || s == ST_RELEASED);
                        if (s == ST_RENDER)
                            s = ST_RENDER_RELEASE;
                        else if (s != ST_RENDER_RELEASE)
                            s = ST_FREE;
                    end
                    default:
                    begin
                        // displayed
                        if (s == ST_RENDER_RELEASE)
                            s = ST_FREE;
                        else if (s == ST_RENDER)
                            s = ST_RELEASED;
                        else
                            res.order_error = 1'b1;
                    end
                endcase
                status[idx]    = s;
                res.new_status = s;
            end
            grants       += res.granted;
            exhausted    += res.no_free;
            order_errors += res.order_error;
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                failures++;
            end
        endfunction

        // Compare one result transfer with the oldest outcome
        function void check_result(logic [M_TDATA_W-1:0] data);
            pool_outcome_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, data);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("granted", 8'(want.granted), 8'(data[0]));
            compare_field("grant_index", 8'(want.grant_index), 8'(data[4:1]));
            compare_field("no_free", 8'(want.no_free), 8'(data[5]));
            compare_field("order_error", 8'(want.order_error), 8'(data[6]));
            compare_field("new_status", 8'(want.new_status), 8'(data[9:7]));
            compare_field("pad", 8'd0, 8'(data[15:10]));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_data;

    surface_ledger ledger;
    bit            calm;
    int unsigned   alloc_pct;

    render_surface_pool u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            3: return MASK_W'($urandom) & MASK_W'($urandom);
            default: return MASK_W'($urandom);
        endcase
    endfunction

    // One request transfer on the slave side
    task automatic send_request(input action_t act, input logic [IDX_W-1:0] idx,
                                input logic [MASK_W-1:0] mask);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W - MASK_W - IDX_W){1'b0}}, mask, idx};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        ledger.note_request(act, idx, mask);
    endtask

    // Hold off requests until every outstanding result has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (ledger.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_query(input bit value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        ledger.query_on = value;
    endtask

    // Mostly legal life-cycle steps on random surfaces, some noise
    task automatic send_random();
        action_t           act;
        logic [IDX_W-1:0]  idx;
        logic [MASK_W-1:0] mask;
        idx  = IDX_W'($urandom);
        mask = pick_mask();
        if ($urandom_range(0, 99) < 12)
            act = action_t'($urandom_range(0, 3));
        else if ($urandom_range(0, 99) < alloc_pct)
            act = ACT_ALLOCATE;
        else
        begin
            case (ledger.status[idx])
                ST_FREE:           act = ACT_ALLOCATE;
                ST_ALOC:           act = ($urandom_range(0, 4) == 0) ? ACT_RELEASE : ACT_RENDER;
                ST_RENDER:         act = $urandom_range(0, 1) ? ACT_RELEASE : ACT_DISPLAYED;
                ST_RENDER_RELEASE: act = ACT_DISPLAYED;
                default:           act = ACT_RELEASE;
            endcase
        end
        send_request(act, idx, mask);
    endtask

    // Result side: check every transfer, stall at random
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                ledger.check_result(m_tdata);
            if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Main sequence
    initial
    begin
        ledger    = new();
        calm      = 1'b0;
        alloc_pct = 30;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_ALLOCATE;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: exhaustion, wrap of the head, out-of-order render, release and displayed requests
        send_request(ACT_ALLOCATE, 4'd0, 16'h0000);
        send_request(ACT_ALLOCATE, 4'd9, 16'hFFFF);
        send_request(ACT_ALLOCATE, 4'd0, 16'h8000);
        send_request(ACT_ALLOCATE, 4'd15, 16'h0001);
        send_request(ACT_RENDER, 4'd0, 16'hFFFF);
        send_request(ACT_RENDER, 4'd5, 16'h0000);
        send_request(ACT_RELEASE, 4'd0, 16'hA5A5);
        send_request(ACT_RELEASE, 4'd0, 16'h5A5A);
        send_request(ACT_DISPLAYED, 4'd0, 16'h0000);
        send_request(ACT_DISPLAYED, 4'd5, 16'hFFFF);
        send_request(ACT_RELEASE, 4'd5, 16'h0000);
        send_request(ACT_RELEASE, 4'd5, 16'h0000);
        send_request(ACT_DISPLAYED, 4'd15, 16'h0000);
        send_request(ACT_RELEASE, 4'd15, 16'h0000);
        send_request(ACT_DISPLAYED, 4'd3, 16'h0000);
        send_request(ACT_RENDER, 4'd15, 16'h0000);
        send_request(ACT_DISPLAYED, 4'd15, 16'h0000);
        send_request(ACT_DISPLAYED, 4'd15, 16'h0000);
        send_request(ACT_RENDER, 4'd10, 16'h0000);
        send_request(ACT_RENDER, 4'd10, 16'h0000);

        // Querying off: readiness mask is ignored
        write_query(1'b0);
        send_request(ACT_ALLOCATE, 4'd7, 16'h0000);
        send_request(ACT_ALLOCATE, 4'd0, 16'h0001);
        send_request(ACT_ALLOCATE, 4'd15, 16'hFFFF);

        // Random phases alternate the query setting and pick a new allocate pressure
        for (int phase = 0; phase < 6; phase++)
        begin
            write_query(phase[0] ? 1'b0 : 1'b1);
            alloc_pct = $urandom_range(20, 70);
            for (int k = 0; k < 300; k++)
            begin
                if (k % 60 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (k == 150 && phase == 2)
                    drain();
                send_random();
            end
        end

        drain();
        calm = 1'b0;
        repeat (24) @(posedge clk);
        $display("covered %0d results: %0d grants, %0d allocates with no free surface,",
                 ledger.checked, ledger.grants, ledger.exhausted);
        $display("%0d order errors, querying both on and off", ledger.order_errors);
        if (ledger.failures == 0 && ledger.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(2_000_000);
        $display("timeout with %0d results outstanding", ledger.pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
